>>> hw/rtl/kmp_substring_matcher_defines.svh
// ----------------------------------------------------------------------------
// kmp_substring_matcher_defines.svh
// Assertion macros used by the substring matcher RTL.
// ----------------------------------------------------------------------------
`ifndef KMP_SUBSTRING_MATCHER_DEFINES_SVH
`define KMP_SUBSTRING_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define KMP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define KMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and constants of the substring matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int BYTE_W        = 8;
    localparam int PATTERN_BYTES = 32;
    localparam int PAT_IDX_W     = 5;
    localparam int WORD_W        = 64;
    localparam int NUM_WORDS     = 4;
    localparam int LEN_W         = 6;
    localparam int CFG_INDEX_W   = 3;
    localparam int START_W       = 10;
    localparam int OUT_DATA_W    = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

    typedef struct packed {
        logic [NUM_WORDS-1:0][WORD_W-1:0] words;
        logic [LEN_W-1:0]                 len;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic               found;
        logic [START_W-1:0] start;
    } res_t;

endpackage

>>> hw/rtl/kmp_substring_matcher.sv
// ----------------------------------------------------------------------------
// kmp_substring_matcher
// Streaming first-occurrence search of a configured pattern in byte texts.
// ----------------------------------------------------------------------------
// Each text arrives one byte per transfer on the slave stream, its first byte
// flagged in tuser and its last byte in tlast, and produces exactly one
// transfer on the master stream: found with the start offset as soon as the
// first match completes, or not found at the last byte. A byte is compared in
// S_M_CMP; each fallback through the failure table passes through S_M_WAIT
// for the registered read of the table memory. A result waits in S_EMIT
// until the output register takes it, and a match that starts at or beyond
// MAX_TEXT is not reported but passes through S_M_FALL. The first byte of a
// text also builds the failure table, in S_BLD_LOADI and S_BLD_CMP for each
// pattern byte after the first plus S_BLD_WAIT per fallback. Bytes that follow
// a delivered result, up to the next first byte, are taken and dropped. The
// pattern is captured at each first byte, so register writes affect the next
// text only. The result sits in an output register, so the next byte is taken
// while it waits. The failure table needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "kmp_substring_matcher_defines.svh"

module kmp_substring_matcher
#(
    parameter int MAX_PATTERN = 32,
    parameter int MAX_TEXT    = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [kmp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [kmp_pkg::WORD_W-1:0]          cfg_data,
    // Text byte stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [kmp_pkg::BYTE_W-1:0]          s_axis_tdata,  // [7:0] text_byte
    input  logic [0:0]                          s_axis_tuser,  // [0] first_of_text
    input  logic                                s_axis_tlast,  // last_of_text
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [kmp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [9:0] match_start
    output logic [0:0]                          m_axis_tuser   // [0] found
);
    import kmp_pkg::*;

    localparam int PAT_CAP = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
    localparam int IDX_W   = $clog2(PAT_CAP);

    cfg_t             cfg;
    res_t             res;
    logic             res_ready;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [IDX_W-1:0] mem_rdata;

    logic               out_valid_reg;
    logic               out_found_reg;
    logic [START_W-1:0] out_start_reg;

    kmp_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kmp_fail_mem
    #(
        .DEPTH  (PAT_CAP),
        .ADDR_W (IDX_W)
    )
    u_fail_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    kmp_search_ctrl
    #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT),
        .IDX_W       (IDX_W)
    )
    u_search_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_first  (s_axis_tuser[0]),
        .in_last   (s_axis_tlast),
        .res       (res),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // The output register takes a new result whenever it is empty or its
    // current transfer completes in the same cycle.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_start_reg <= '0;
        end
        else if (res.valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
            out_found_reg <= res.found;
            out_start_reg <= res.start;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = OUT_DATA_W'(out_start_reg);
    assign m_axis_tuser[0] = out_found_reg;

    // The sequencer never takes a byte while it offers a result.
    `KMP_ASSERT_SAME(a_no_accept_while_emit, res.valid, !s_axis_tready, "byte taken during emit")
    // A result handed over always shows up on the master stream next cycle.
    `KMP_ASSERT_NEXT(a_result_reaches_port, res.valid && res_ready, m_axis_tvalid, "result lost")
    // A not-found result carries a zero offset.
    `KMP_ASSERT_SAME(a_not_found_zero, m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata == '0, "not-found result with nonzero offset")

endmodule

>>> hw/rtl/kmp_cfg_regs.sv
// ----------------------------------------------------------------------------
// kmp_cfg_regs
// Pattern words and pattern length written through the configuration port.
// ----------------------------------------------------------------------------
module kmp_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [kmp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [kmp_pkg::WORD_W-1:0]       cfg_data,
    output kmp_pkg::cfg_t                    cfg
);
    import kmp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.words <= '0;
            cfg_reg.len   <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_WORD_0: cfg_reg.words[0] <= cfg_data;
                REG_PATTERN_WORD_1: cfg_reg.words[1] <= cfg_data;
                REG_PATTERN_WORD_2: cfg_reg.words[2] <= cfg_data;
                REG_PATTERN_WORD_3: cfg_reg.words[3] <= cfg_data;
                REG_PATTERN_LENGTH: cfg_reg.len      <= cfg_data[LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/kmp_fail_mem.sv
// ----------------------------------------------------------------------------
// kmp_fail_mem
// Failure table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kmp_fail_mem
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ADDR_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [ADDR_W-1:0] rdata
);

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Entry 0 is the border of a one-byte prefix and always reads as zero,
    // so it never needs to be written. A write to the entry being read is
    // forwarded.
    always_ff @(posedge clk)
    begin
        if (raddr == '0)
        begin
            rdata_reg <= '0;
        end
        else if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/kmp_search_ctrl.sv
// ----------------------------------------------------------------------------
// kmp_search_ctrl
// Sequencer for table build and per-byte matching around the failure table.
// ----------------------------------------------------------------------------
module kmp_search_ctrl
#(
    parameter int MAX_PATTERN = 32,
    parameter int MAX_TEXT    = 1024,
    parameter int IDX_W       = 5
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  kmp_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [kmp_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        in_first,
    input  logic                        in_last,
    output kmp_pkg::res_t               res,
    input  logic                        res_ready,
    output logic                        mem_we,
    output logic [IDX_W-1:0]            mem_waddr,
    output logic [IDX_W-1:0]            mem_wdata,
    output logic [IDX_W-1:0]            mem_raddr,
    input  logic [IDX_W-1:0]            mem_rdata
);
    import kmp_pkg::*;

    localparam int PAT_CAP = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
    localparam int CNT_W   = $clog2(PAT_CAP + 1);
    localparam int POS_CAP = MAX_TEXT + MAX_PATTERN;
    localparam int POS_W   = $clog2(POS_CAP + 1);
    localparam int SUM_W   = POS_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLD_LOADI,
        S_BLD_CMP,
        S_BLD_WAIT,
        S_M_CMP,
        S_M_WAIT,
        S_M_FALL,
        S_EMIT
    } state_t;

    state_t                                state_reg;
    logic [PATTERN_BYTES-1:0][BYTE_W-1:0]  pat_reg;
    logic [CNT_W-1:0]                      pat_len_reg;
    logic [IDX_W-1:0]                      i_reg;
    logic [IDX_W-1:0]                      k_reg;
    logic [IDX_W-1:0]                      m_reg;
    logic [BYTE_W-1:0]                     pi_reg;
    logic [BYTE_W-1:0]                     byte_reg;
    logic                                  last_reg;
    logic                                  given_reg;
    logic [POS_W-1:0]                      pos_reg;
    logic [POS_W-1:0]                      pos_cur_reg;
    logic                                  found_reg;
    logic [START_W-1:0]                    start_reg;

    logic [LEN_W-1:0]  len_sat;
    logic [IDX_W-1:0]  pat_addr;
    logic [BYTE_W-1:0] pat_byte;
    logic              pi_eq;
    logic              b_eq;
    logic              k_fall;
    logic              m_fall;
    logic [IDX_W-1:0]  k_new;
    logic [CNT_W-1:0]  j_new;
    logic              full;
    logic              bld_last;
    logic [SUM_W-1:0]  start_val;
    logic              start_ok;

    always_comb
    begin
        // A zero length counts as one; lengths above the table size saturate.
        if (cfg.len == '0)
        begin
            len_sat = LEN_W'(1);
        end
        else if (cfg.len > LEN_W'(PAT_CAP))
        begin
            len_sat = LEN_W'(PAT_CAP);
        end
        else
        begin
            len_sat = cfg.len;
        end

        case (state_reg)
            S_BLD_LOADI: pat_addr = i_reg;
            S_BLD_CMP:   pat_addr = k_reg;
            default:     pat_addr = m_reg;
        endcase
        pat_byte = pat_reg[PAT_IDX_W'(pat_addr)];

        pi_eq     = (pi_reg == pat_byte);
        b_eq      = (byte_reg == pat_byte);
        k_fall    = (k_reg != '0) && !pi_eq;
        m_fall    = (m_reg != '0) && !b_eq;
        k_new     = k_reg + IDX_W'(pi_eq);
        j_new     = CNT_W'(m_reg) + CNT_W'(b_eq);
        full      = (j_new == pat_len_reg);
        bld_last  = ((CNT_W'(i_reg) + CNT_W'(1)) == pat_len_reg);
        start_val = SUM_W'(pos_cur_reg) + SUM_W'(1) - SUM_W'(pat_len_reg);
        start_ok  = (start_val < SUM_W'(MAX_TEXT));

        mem_we    = (state_reg == S_BLD_CMP) && !k_fall;
        mem_waddr = i_reg;
        mem_wdata = k_new;
        case (state_reg)
            S_BLD_CMP: mem_raddr = k_reg - IDX_W'(1);
            S_M_CMP:
            begin
                if (!m_fall && full)
                begin
                    mem_raddr = IDX_W'(pat_len_reg - CNT_W'(1));
                end
                else
                begin
                    mem_raddr = m_reg - IDX_W'(1);
                end
            end
            default:   mem_raddr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pat_reg     <= '0;
            pat_len_reg <= CNT_W'(1);
            i_reg       <= '0;
            k_reg       <= '0;
            m_reg       <= '0;
            pi_reg      <= '0;
            byte_reg    <= '0;
            last_reg    <= 1'b0;
            given_reg   <= 1'b0;
            pos_reg     <= '0;
            pos_cur_reg <= '0;
            found_reg   <= 1'b0;
            start_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        byte_reg <= in_byte;
                        last_reg <= in_last;
                        if (in_first)
                        begin
                            pat_reg     <= cfg.words;
                            pat_len_reg <= CNT_W'(len_sat);
                            m_reg       <= '0;
                            given_reg   <= 1'b0;
                            pos_cur_reg <= '0;
                            pos_reg     <= POS_W'(1);
                            i_reg       <= IDX_W'(1);
                            k_reg       <= '0;
                            state_reg   <= (len_sat > LEN_W'(1)) ? S_BLD_LOADI : S_M_CMP;
                        end
                        else if (!given_reg)
                        begin
                            pos_cur_reg <= pos_reg;
                            if (pos_reg < POS_W'(POS_CAP))
                            begin
                                pos_reg <= pos_reg + POS_W'(1);
                            end
                            state_reg <= S_M_CMP;
                        end
                    end
                end
                S_BLD_LOADI:
                begin
                    pi_reg    <= pat_byte;
                    state_reg <= S_BLD_CMP;
                end
                S_BLD_CMP:
                begin
                    if (k_fall)
                    begin
                        state_reg <= S_BLD_WAIT;
                    end
                    else
                    begin
                        k_reg <= k_new;
                        if (bld_last)
                        begin
                            state_reg <= S_M_CMP;
                        end
                        else
                        begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= S_BLD_LOADI;
                        end
                    end
                end
                S_BLD_WAIT:
                begin
                    k_reg     <= mem_rdata;
                    state_reg <= S_BLD_CMP;
                end
                S_M_CMP:
                begin
                    if (m_fall)
                    begin
                        state_reg <= S_M_WAIT;
                    end
                    else if (full)
                    begin
                        if (start_ok)
                        begin
                            m_reg     <= '0;
                            given_reg <= 1'b1;
                            found_reg <= 1'b1;
                            start_reg <= START_W'(start_val);
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            // Too late to report: keep searching from the border.
                            state_reg <= S_M_FALL;
                        end
                    end
                    else
                    begin
                        m_reg <= IDX_W'(j_new);
                        if (last_reg)
                        begin
                            given_reg <= 1'b1;
                            found_reg <= 1'b0;
                            start_reg <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_M_WAIT:
                begin
                    m_reg     <= mem_rdata;
                    state_reg <= S_M_CMP;
                end
                S_M_FALL:
                begin
                    m_reg <= mem_rdata;
                    if (last_reg)
                    begin
                        given_reg <= 1'b1;
                        found_reg <= 1'b0;
                        start_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res.valid = (state_reg == S_EMIT);
    assign res.found = found_reg;
    assign res.start = start_reg;

endmodule
